/* rtl/vrra_pkg.sv */
// Shared types and constants for the variable record ring allocator.
package vrra_pkg;

	localparam int RING_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int CFG_W            = 13;
	localparam int LEN_W            = 12;
	localparam int OFF_W            = 12;

	localparam logic [CFG_W-1:0] RING_SIZE_RST = 13'd4096;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_NONE = 2'd1,
		STATUS_FAIL = 2'd2
	} status_t;

	typedef struct packed {
		logic             operation;
		logic [LEN_W-1:0] length;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [OFF_W-1:0] payload_offset;
		logic [LEN_W-1:0] record_length;
	} res_t;

	typedef struct packed {
		logic             has_data;
		logic [LEN_W-1:0] len;
	} hdr_t;

endpackage

/* rtl/variable_record_ring_allocator.sv */
// Top level: sequencer, positions and header store of the record ring allocator.

// A request beat is taken when start is high and busy is low; busy then stays
// high until the result is shown. Every request gives exactly one result beat,
// held on res for one cycle with done high; it cannot be stalled, so the user
// must take it in that cycle. An attempt passes through an evaluate and a
// decide state, plus a commit state when a record is placed or taken, all on
// one shared add/subtract unit and the registered read of the header store.
// A request that wraps to offset zero tries again once. The ring size
// register may be written only while busy is low.
module variable_record_ring_allocator #(
	parameter int RING_BYTES   = vrra_pkg::RING_BYTES_DEF,
	parameter int HEADER_BYTES = vrra_pkg::HEADER_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  vrra_pkg::req_t             req,
	output logic                       done,
	output vrra_pkg::res_t             res,
	input  logic                       cfg_we,
	input  logic [vrra_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int PosW  = $clog2(RING_BYTES + 1);
	localparam int AddrW = $clog2(RING_BYTES);
	localparam int CmpW  = (PosW > vrra_pkg::CFG_W) ? PosW : vrra_pkg::CFG_W;
	localparam int HdrW  = $bits(vrra_pkg::hdr_t);

	localparam logic [CmpW-1:0] HDR_C = CmpW'(HEADER_BYTES);
	localparam logic [CmpW-1:0] N_LO  = CmpW'(HEADER_BYTES + 1);
	localparam logic [CmpW-1:0] N_HI  = CmpW'(RING_BYTES);

	typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DECIDE, S_COMMIT} state_t;

	state_t                       state_q;
	logic                         op_q;
	logic [vrra_pkg::LEN_W-1:0]   len_q;
	logic [PosW-1:0]              rpos_q;
	logic [PosW-1:0]              wpos_q;
	logic [vrra_pkg::CFG_W-1:0]   ring_size_q;
	logic [CmpW-1:0]              gap_q;
	logic [CmpW-1:0]              addend_q;
	logic                         ge_q;
	logic                         eq_q;
	logic                         second_q;
	logic                         done_q;
	vrra_pkg::res_t               res_q;

	logic [CmpW-1:0] rs_ext, n_ext, r_ext, w_ext;
	logic            w_ge_r, r_gt_w, r_eq_w;
	logic            alu_sub;
	logic [CmpW-1:0] alu_a, alu_b;
	logic [CmpW:0]   alu_y;
	logic            borrow, nz;
	logic [CmpW-1:0] diff, addend, off_sum;
	logic [HdrW-1:0] ram_rdata;
	vrra_pkg::hdr_t  hdr_rd, hdr_wr;
	logic [CmpW-1:0] pad_len;
	logic            ram_we, fit;
	logic            dec_take, dec_fail, dec_retry, dec_wrap_w, dec_wrap_r;

	assign rs_ext = CmpW'(ring_size_q);
	assign n_ext  = (rs_ext > N_HI) ? N_HI : ((rs_ext < N_LO) ? N_LO : rs_ext);
	assign r_ext  = CmpW'(rpos_q);
	assign w_ext  = CmpW'(wpos_q);
	assign w_ge_r = wpos_q >= rpos_q;
	assign r_gt_w = rpos_q > wpos_q;
	assign r_eq_w = rpos_q == wpos_q;
	assign hdr_rd = vrra_pkg::hdr_t'(ram_rdata);

	assign addend  = (op_q ? CmpW'(hdr_rd.len) : CmpW'(len_q)) + HDR_C;
	assign off_sum = (op_q ? r_ext : w_ext) + HDR_C;
	assign pad_len = gap_q - HDR_C;

	always_comb begin
		alu_sub = 1'b1;
		alu_a   = '0;
		alu_b   = '0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_EVAL: begin
				if (op_q == vrra_pkg::OP_WRITE) begin
					alu_a = w_ge_r ? n_ext : r_ext;
					alu_b = w_ext;
				end else begin
					alu_a = r_gt_w ? n_ext : w_ext;
					alu_b = r_ext;
				end
			end
			S_DECIDE: begin
				alu_a = gap_q;
				alu_b = addend;
			end
			S_COMMIT: begin
				alu_sub = 1'b0;
				alu_a   = op_q ? r_ext : w_ext;
				alu_b   = addend_q;
			end
		endcase
	end

	vrra_alu #(.W(CmpW)) u_alu (
		.sub (alu_sub),
		.a   (alu_a),
		.b   (alu_b),
		.y   (alu_y)
	);

	assign borrow = alu_y[CmpW];
	assign diff   = alu_y[CmpW-1:0];
	assign nz     = |diff;
	assign fit    = ge_q ? !borrow : (!borrow && nz);

	always_comb begin
		dec_take   = 1'b0;
		dec_fail   = 1'b0;
		dec_retry  = 1'b0;
		dec_wrap_w = 1'b0;
		dec_wrap_r = 1'b0;
		if (op_q == vrra_pkg::OP_WRITE) begin
			if (fit) begin
				dec_take = 1'b1;
			end else if (ge_q && rpos_q != '0) begin
				dec_wrap_w = 1'b1;
				dec_retry  = 1'b1;
			end else begin
				dec_fail = 1'b1;
			end
		end else begin
			if (eq_q) begin
				dec_retry = 1'b1;
			end else if (ge_q) begin
				if (gap_q <= HDR_C || !hdr_rd.has_data) begin
					dec_wrap_r = 1'b1;
					dec_retry  = 1'b1;
				end else begin
					dec_take = 1'b1;
				end
			end else if (gap_q <= HDR_C || borrow) begin
				dec_fail = 1'b1;
			end else begin
				dec_take = 1'b1;
			end
		end
	end

	// data header when placed, padding header when the tail is too short
	always_comb begin
		hdr_wr.has_data = fit;
		hdr_wr.len      = fit ? len_q : pad_len[vrra_pkg::LEN_W-1:0];
		ram_we          = (state_q == S_DECIDE) && (op_q == vrra_pkg::OP_WRITE)
		                  && (fit || (ge_q && gap_q >= HDR_C));
	end

	vrra_ram #(.WIDTH(HdrW), .DEPTH(RING_BYTES)) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wpos_q[AddrW-1:0]),
		.wdata (hdr_wr),
		.raddr (rpos_q[AddrW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= vrra_pkg::RING_SIZE_RST;
		end else if (cfg_we) begin
			ring_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= vrra_pkg::OP_WRITE;
			len_q    <= '0;
			rpos_q   <= '0;
			wpos_q   <= '0;
			gap_q    <= '0;
			addend_q <= '0;
			ge_q     <= 1'b0;
			eq_q     <= 1'b0;
			second_q <= 1'b0;
			done_q   <= 1'b0;
			res_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= req.operation;
						len_q    <= req.length;
						second_q <= 1'b0;
						state_q  <= S_EVAL;
					end
				end
				S_EVAL: begin
					gap_q   <= borrow ? '0 : diff;
					ge_q    <= op_q ? r_gt_w : w_ge_r;
					eq_q    <= r_eq_w;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (dec_wrap_w) begin
						wpos_q <= '0;
					end
					if (dec_wrap_r) begin
						rpos_q <= '0;
					end
					if (dec_take) begin
						res_q.status         <= vrra_pkg::STATUS_OK;
						res_q.payload_offset <= off_sum[vrra_pkg::OFF_W-1:0];
						res_q.record_length  <= op_q ? hdr_rd.len : len_q;
						addend_q             <= addend;
						state_q              <= S_COMMIT;
					end else if (dec_fail) begin
						res_q   <= '{vrra_pkg::STATUS_FAIL, '0, '0};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (dec_retry && !second_q) begin
						second_q <= 1'b1;
						state_q  <= S_EVAL;
					end else begin
						res_q   <= '{vrra_pkg::STATUS_NONE, '0, '0};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_COMMIT: begin
					if (op_q == vrra_pkg::OP_READ) begin
						rpos_q <= alu_y[PosW-1:0];
					end else begin
						wpos_q <= alu_y[PosW-1:0];
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign res  = res_q;

endmodule

/* rtl/vrra_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module vrra_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/vrra_alu.sv */
// Shared add/subtract unit; the top bit is carry, or borrow when subtracting.
module vrra_alu #(
	parameter int W = 13
) (
	input  logic         sub,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W:0]   y
);

	always_comb begin
		if (sub) begin
			y = {1'b0, a} - {1'b0, b};
		end else begin
			y = {1'b0, a} + {1'b0, b};
		end
	end

endmodule
